@@ design/pps_pkg.sv @@
// shared types and constants for the plug poll scheduler table
// no dependencies
`timescale 1ns / 1ps

package pps_pkg;

  localparam int unsigned ScanGapMs = 500;
  localparam int unsigned MsPerS    = 1000;

  typedef enum logic {
    MODE_REPORT = 1'b0,
    MODE_TICK   = 1'b1
  } mode_t;

  // one queued transaction between front and back
  typedef struct packed {
    mode_t       mode;
    logic [23:0] plug_id;
    logic [7:0]  report_channel;
    logic [31:0] now_ms;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic        was_known;
    logic        settings_changed;
    logic        table_full;
    logic        poll_sent;
    logic [7:0]  poll_channel;
    logic [23:0] poll_plug_id;
    logic [7:0]  next_free_channel;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_FREE,
    ST_OUT
  } state_t;

endpackage

@@ design/plug_poll_scheduler_table_core.sv @@
// plug poll scheduler table, top level
// depends on pps_pkg, pps_front, pps_back
`timescale 1ns / 1ps
// Usage: in_ carries a report (tuser 0) or a time tick (tuser 1); each
// accepted transaction yields exactly one out_ transaction.
// A two-entry queue lets the input side accept while the back part works.
// Per item the back part reads the table through its single read port,
// one entry per cycle: a scan over at most the E table entries in use,
// then a free-channel search that tries F channels (F <= E+1, as E
// entries block at most E channels), each against every entry in use.
// Items are handled one at a time in arrival order; the back part takes
// no new item until the result of the last one has been taken.
// Reset empties the table, clears the scan time and sets the poll interval
// to 60 s. While out_tready is low the result holds and the back part
// waits; the input queue fills then stalls in_tready.
// cfg_we writes poll_interval_s; write it only when idle.

module plug_poll_scheduler_table_core #(
  parameter int MAX_PLUGS     = 16,
  parameter int CHANNEL_LIMIT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // plug_id[23:0], report_channel[31:24], now_ms[63:32]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // poll_channel[7:0], poll_plug_id[31:8], next_free_channel[39:32]
  output logic [3:0]  out_tuser,  // was_known, settings_changed, table_full, poll_sent
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import pps_pkg::*;

  logic        q_valid, q_pop;
  item_t       q_item;
  result_t     res;
  logic [15:0] interval_r;

  // poll interval register
  always_ff @(posedge clk) begin
    if (!rst_n) interval_r <= 16'd60;
    else if (cfg_we) interval_r <= cfg_wdata;
  end

  pps_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_pop, .q_item
  );

  pps_back #(.MAX_PLUGS(MAX_PLUGS), .CHANNEL_LIMIT(CHANNEL_LIMIT)) u_back (
    .clk, .rst_n, .poll_interval_s(interval_r), .q_valid, .q_pop, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {res.next_free_channel, res.poll_plug_id, res.poll_channel};
  assign out_tuser = {res.poll_sent, res.table_full, res.settings_changed, res.was_known};

endmodule

@@ design/pps_front.sv @@
// input side: accepts transactions and holds them in a two-entry queue
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic                in_tuser,
  output logic                q_valid,
  input  logic                q_pop,
  output pps_pkg::item_t      q_item
);
  import pps_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      it;

  // classify incoming fields into an item
  always_comb begin
    it.mode           = mode_t'(in_tuser);
    it.plug_id        = in_tdata[23:0];
    it.report_channel = in_tdata[31:24];
    it.now_ms         = in_tdata[63:32];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rp_r];

  // pointer update
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= it;
    end
  end

endmodule

@@ design/pps_back.sv @@
// back side: walks the table for one item, updates it and builds its result
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_back #(
  parameter int MAX_PLUGS     = 16,
  parameter int CHANNEL_LIMIT = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         poll_interval_s,
  input  logic                q_valid,
  output logic                q_pop,
  input  pps_pkg::item_t      q_item,
  output logic                res_valid,
  input  logic                res_ready,
  output pps_pkg::result_t    res
);
  import pps_pkg::*;

  localparam int IW = (MAX_PLUGS > 1) ? $clog2(MAX_PLUGS) : 1;
  localparam int CW = $clog2(MAX_PLUGS + 1);

  logic [23:0] id_mem   [MAX_PLUGS];
  logic [7:0]  ch_mem   [MAX_PLUGS];
  logic [31:0] lp_mem   [MAX_PLUGS];

  state_t      st_r, st_nxt;
  item_t       cur_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic        hit_r;
  logic [IW-1:0] hit_idx_r;
  logic [31:0] last_scan_r;
  logic [31:0] span_r;
  logic        gate_r;
  logic [7:0]  ch_r;
  logic        used_r;
  result_t     res_r;

  logic [IW-1:0] ia;
  logic [23:0] e_id;
  logic [7:0]  e_ch;
  logic [31:0] e_lp;
  logic        in_range;
  logic        due;
  logic [31:0] base_scan;

  assign ia       = idx_r[IW-1:0];
  assign e_id     = id_mem[ia];
  assign e_ch     = ch_mem[ia];
  assign e_lp     = lp_mem[ia];
  assign in_range = (idx_r < count_r);
  assign due      = (cur_r.now_ms > (e_lp + span_r)) || (cur_r.now_ms < e_lp);
  assign base_scan = (q_item.now_ms < last_scan_r) ? 32'd0 : last_scan_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid) st_nxt = ST_SCAN;
      ST_SCAN:  begin
        if (!in_range || hit_r ||
            (cur_r.mode == MODE_REPORT && e_id == cur_r.plug_id) ||
            (cur_r.mode == MODE_TICK && (!gate_r || due))) begin
          st_nxt = ST_APPLY;
        end
      end
      ST_APPLY: st_nxt = ST_FREE;
      ST_FREE:  begin
        if (!used_r && ch_r != 8'd0 && idx_r >= count_r) st_nxt = ST_OUT;
        else if (ch_r == CHANNEL_LIMIT[7:0] && used_r && idx_r >= count_r) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT:   if (res_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (st_r == ST_IDLE);
    res_valid = (st_r == ST_OUT);
    res       = res_r;
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      last_scan_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r     <= q_item;
            idx_r     <= '0;
            hit_r     <= 1'b0;
            res_r     <= '0;
            span_r    <= 32'(poll_interval_s * 32'(MsPerS));
            gate_r    <= (q_item.now_ms > (base_scan + 32'(ScanGapMs)));
            if (q_item.mode == MODE_TICK) begin
              last_scan_r <= base_scan;
            end
          end
        end
        ST_SCAN: begin
          if (in_range && !hit_r) begin
            if ((cur_r.mode == MODE_REPORT && e_id == cur_r.plug_id) ||
                (cur_r.mode == MODE_TICK && gate_r && due)) begin
              hit_r     <= 1'b1;
              hit_idx_r <= ia;
            end else if (!(cur_r.mode == MODE_TICK && !gate_r)) begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_APPLY: begin
          if (cur_r.mode == MODE_REPORT) begin
            if (hit_r) begin
              res_r.was_known <= 1'b1;
              res_r.settings_changed <= (ch_mem[hit_idx_r] != cur_r.report_channel);
            end else if (count_r < CW'(MAX_PLUGS)) begin
              count_r <= count_r + 1'b1;
              res_r.settings_changed <= 1'b1;
            end else begin
              res_r.table_full <= 1'b1;
            end
          end else if (gate_r) begin
            last_scan_r <= cur_r.now_ms;
            if (hit_r) begin
              res_r.poll_sent    <= 1'b1;
              res_r.poll_channel <= ch_mem[hit_idx_r];
              res_r.poll_plug_id <= id_mem[hit_idx_r];
            end
          end
          ch_r   <= 8'd1;
          idx_r  <= '0;
          used_r <= 1'b0;
        end
        ST_FREE: begin
          // channel search, one entry compare per cycle
          if (idx_r < count_r) begin
            if (e_ch == ch_r) used_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end else if (!used_r) begin
            res_r.next_free_channel <= ch_r;
          end else if (ch_r == CHANNEL_LIMIT[7:0]) begin
            res_r.next_free_channel <= 8'd0;
          end else begin
            ch_r   <= ch_r + 8'd1;
            used_r <= 1'b0;
            idx_r  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // table storage writes
  always_ff @(posedge clk) begin
    if (st_r == ST_APPLY) begin
      if (cur_r.mode == MODE_REPORT) begin
        if (hit_r) begin
          ch_mem[hit_idx_r] <= cur_r.report_channel;
          lp_mem[hit_idx_r] <= cur_r.now_ms;
        end else if (count_r < CW'(MAX_PLUGS)) begin
          id_mem[count_r[IW-1:0]] <= cur_r.plug_id;
          ch_mem[count_r[IW-1:0]] <= cur_r.report_channel;
          lp_mem[count_r[IW-1:0]] <= cur_r.now_ms;
        end
      end else if (gate_r && hit_r) begin
        lp_mem[hit_idx_r] <= cur_r.now_ms;
      end
    end
  end

endmodule
